// ===== rtl/ebdc_pkg.sv =====
// Shared codes, reset values and types for the encoder balanced drive controller.
`default_nettype none

package ebdc_pkg;

   // transaction kinds on the request channel (req_tuser)
   localparam logic [1:0] CMD_START      = 2'd0;
   localparam logic [1:0] CMD_LEFT_EDGE  = 2'd1;
   localparam logic [1:0] CMD_RIGHT_EDGE = 2'd2;
   localparam logic [1:0] CMD_TICK       = 2'd3;

   // move codes carried by a start transaction
   localparam logic [2:0] KIND_STOP    = 3'd0;
   localparam logic [2:0] KIND_FORWARD = 3'd1;
   localparam logic [2:0] KIND_BACK    = 3'd2;
   localparam logic [2:0] KIND_RIGHT   = 3'd3;
   localparam logic [2:0] KIND_LEFT    = 3'd4;

   // register indexes
   localparam logic [2:0] REG_FWD_DIST   = 3'd0;
   localparam logic [2:0] REG_BACK_DIST  = 3'd1;
   localparam logic [2:0] REG_RIGHT_DIST = 3'd2;
   localparam logic [2:0] REG_LEFT_DIST  = 3'd3;
   localparam logic [2:0] REG_LDUTY_MIN  = 3'd4;
   localparam logic [2:0] REG_LDUTY_MAX  = 3'd5;
   localparam logic [2:0] REG_RDUTY_MIN  = 3'd6;
   localparam logic [2:0] REG_RDUTY_MAX  = 3'd7;

   localparam int DIST_W = 15;
   localparam int DUTY_W = 10;
   localparam int CNT_W  = 16;

   localparam logic [DIST_W-1:0] FWD_DIST_RST   = 15'd2100;
   localparam logic [DIST_W-1:0] BACK_DIST_RST  = 15'd2100;
   localparam logic [DIST_W-1:0] RIGHT_DIST_RST = 15'd445;
   localparam logic [DIST_W-1:0] LEFT_DIST_RST  = 15'd470;
   localparam logic [DUTY_W-1:0] LDUTY_MIN_RST  = 10'd800;
   localparam logic [DUTY_W-1:0] LDUTY_MAX_RST  = 10'd950;
   localparam logic [DUTY_W-1:0] RDUTY_MIN_RST  = 10'd650;
   localparam logic [DUTY_W-1:0] RDUTY_MAX_RST  = 10'd850;
   localparam logic [DUTY_W-1:0] LDUTY_RST      = 10'd760;
   localparam logic [DUTY_W-1:0] RDUTY_RST      = 10'd820;

   localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sd32767;
   localparam logic signed [CNT_W-1:0] CNT_MIN = -16'sd32767;

   localparam logic [1:0] TICKS_RST   = 2'd2;
   localparam logic [1:0] TICKS_SAT   = 2'd3;
   localparam logic [1:0] TICKS_DUE   = 2'd2;

   typedef enum logic [4:0] {
      MV_IDLE    = 5'b00001,
      MV_FORWARD = 5'b00010,
      MV_BACK    = 5'b00100,
      MV_RIGHT   = 5'b01000,
      MV_LEFT    = 5'b10000
   } move_type;

   typedef struct packed {
      move_type                  move;
      logic signed [CNT_W-1:0]   left_count;
      logic signed [CNT_W-1:0]   right_count;
      logic signed [CNT_W-1:0]   left_seen;
      logic signed [CNT_W-1:0]   right_seen;
      logic [DUTY_W-1:0]         left_duty;
      logic [DUTY_W-1:0]         right_duty;
      logic [DUTY_W-1:0]         left_min;
      logic [DUTY_W-1:0]         left_max;
      logic [DUTY_W-1:0]         right_min;
      logic [DUTY_W-1:0]         right_max;
   } bal_in_type;

   typedef struct packed {
      logic signed [CNT_W-1:0]   left_seen;
      logic signed [CNT_W-1:0]   right_seen;
      logic [DUTY_W-1:0]         left_duty;
      logic [DUTY_W-1:0]         right_duty;
   } bal_out_type;

endpackage

`default_nettype wire

// ===== rtl/ebdc_balance.sv =====
// Proportional wheel balance step: signed deltas, correction and duty clamps.
`default_nettype none

module ebdc_balance
   import ebdc_pkg::*;
(
   input  bal_in_type  bal_i,
   output bal_out_type bal_o
);

   localparam int DELTA_W = CNT_W + 1;
   localparam int DIFF_W  = CNT_W + 2;
   localparam int ADJ_W   = CNT_W + 3;
   localparam int SUM_W   = CNT_W + 4;

   logic                      neg_left;
   logic                      neg_right;
   logic signed [CNT_W-1:0]   l_cnt;
   logic signed [CNT_W-1:0]   r_cnt;
   logic signed [DELTA_W-1:0] dl;
   logic signed [DELTA_W-1:0] dr;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [ADJ_W-1:0]   adj;
   logic signed [SUM_W-1:0]   lv;
   logic signed [SUM_W-1:0]   rv;
   logic signed [SUM_W-1:0]   lv_lo;
   logic signed [SUM_W-1:0]   rv_lo;
   logic signed [SUM_W-1:0]   l_min;
   logic signed [SUM_W-1:0]   l_max;
   logic signed [SUM_W-1:0]   r_min;
   logic signed [SUM_W-1:0]   r_max;
   logic signed [SUM_W-1:0]   lv_c;
   logic signed [SUM_W-1:0]   rv_c;

   always_comb begin
      // wheel senses per move: back and left turn run the left wheel in reverse,
      // back and right turn the right wheel
      neg_left  = (bal_i.move == MV_BACK) || (bal_i.move == MV_LEFT);
      neg_right = (bal_i.move == MV_BACK) || (bal_i.move == MV_RIGHT);
      l_cnt = neg_left  ? -bal_i.left_count  : bal_i.left_count;
      r_cnt = neg_right ? -bal_i.right_count : bal_i.right_count;

      dl   = DELTA_W'(l_cnt) - DELTA_W'(bal_i.left_seen);
      dr   = DELTA_W'(r_cnt) - DELTA_W'(bal_i.right_seen);
      diff = DIFF_W'(dl) - DIFF_W'(dr);
      adj  = ADJ_W'(diff) <<< 1;

      lv = $signed(SUM_W'({1'b0, bal_i.left_duty}))  - SUM_W'(adj);
      rv = $signed(SUM_W'({1'b0, bal_i.right_duty})) + SUM_W'(adj);

      l_min = $signed(SUM_W'({1'b0, bal_i.left_min}));
      l_max = $signed(SUM_W'({1'b0, bal_i.left_max}));
      r_min = $signed(SUM_W'({1'b0, bal_i.right_min}));
      r_max = $signed(SUM_W'({1'b0, bal_i.right_max}));

      // minimum first, then maximum: the maximum wins when the limits cross
      lv_lo = (lv < l_min) ? l_min : lv;
      lv_c  = (lv_lo > l_max) ? l_max : lv_lo;
      rv_lo = (rv < r_min) ? r_min : rv;
      rv_c  = (rv_lo > r_max) ? r_max : rv_lo;

      bal_o.left_seen  = l_cnt;
      bal_o.right_seen = r_cnt;
      bal_o.left_duty  = lv_c[DUTY_W-1:0];
      bal_o.right_duty = rv_c[DUTY_W-1:0];
   end

endmodule

`default_nettype wire

// ===== rtl/encoder_balanced_drive_controller.sv =====
// Top level: differential drive move controller with encoder balance.
//
//  channel | direction | fields (lowest bit up)
//  req     | in        | tuser: cmd[1:0]; tdata: move_kind[2:0] phase_a[3] phase_b[4], zero [7:5]
//  rsp     | out       | tdata: duty_ch0..duty_ch3 (10 b each) busy_res[40] move_done[41]
//  csr     | in        | csr_we, csr_addr (register index), csr_wdata (15 b)
//
// One transaction per clock in steady state while the response channel is not
// stalled: a request is held in the input register, the single-pass
// decode/threshold/balance logic then updates the move state and loads the
// response register, which presents the response.
// Reset (synchronous) restores config registers, valid flags and move state; no clearing pass.
// A stalled response register holds; the input register keeps taking a request
// whenever its contents move on in the same cycle.
`default_nettype none

module encoder_balanced_drive_controller
   import ebdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // move_kind[2:0], phase_a[3], phase_b[4]
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // duty_ch0[9:0], duty_ch1[19:10], duty_ch2[29:20],
                                         // duty_ch3[39:30], busy_res[40], move_done[41]
   // register writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [14:0] csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [DIST_W-1:0] fwd_dist_ff, back_dist_ff, right_dist_ff, left_dist_ff;
   logic [DUTY_W-1:0] lmin_ff, lmax_ff, rmin_ff, rmax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_dist_ff   <= FWD_DIST_RST;
         back_dist_ff  <= BACK_DIST_RST;
         right_dist_ff <= RIGHT_DIST_RST;
         left_dist_ff  <= LEFT_DIST_RST;
         lmin_ff       <= LDUTY_MIN_RST;
         lmax_ff       <= LDUTY_MAX_RST;
         rmin_ff       <= RDUTY_MIN_RST;
         rmax_ff       <= RDUTY_MAX_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_FWD_DIST:   fwd_dist_ff   <= csr_wdata;
            REG_BACK_DIST:  back_dist_ff  <= csr_wdata;
            REG_RIGHT_DIST: right_dist_ff <= csr_wdata;
            REG_LEFT_DIST:  left_dist_ff  <= csr_wdata;
            REG_LDUTY_MIN:  lmin_ff       <= csr_wdata[DUTY_W-1:0];
            REG_LDUTY_MAX:  lmax_ff       <= csr_wdata[DUTY_W-1:0];
            REG_RDUTY_MIN:  rmin_ff       <= csr_wdata[DUTY_W-1:0];
            REG_RDUTY_MAX:  rmax_ff       <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic in_v_ff, out_v_ff;
   logic adv;   // input register contents processed this cycle

   assign adv        = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || adv;
   assign rsp_tvalid = out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_tready) in_v_ff <= req_tvalid;
         if (adv)                      out_v_ff <= 1'b1;
         else if (rsp_tready)          out_v_ff <= 1'b0;
      end
   end

   // input register (payload, no reset)
   logic [1:0] cmd_ff;
   logic [2:0] kind_ff;
   logic       pa_ff, pb_ff;

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff  <= req_tuser;
         kind_ff <= req_tdata[2:0];
         pa_ff   <= req_tdata[3];
         pb_ff   <= req_tdata[4];
      end
   end

   // ---------------- move state ----------------
   move_type                move_ff, move_in;
   logic signed [CNT_W-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic signed [CNT_W-1:0] lseen_ff, lseen_in, rseen_ff, rseen_in;
   logic [DUTY_W-1:0]       lduty_ff, lduty_in, rduty_ff, rduty_in;
   logic [1:0]              ticks_ff, ticks_in;

   // after the command's own effect, before the threshold check
   move_type                move_a;
   logic signed [CNT_W-1:0] lcnt_a, rcnt_a;
   logic [1:0]              ticks_a;
   logic [CNT_W-2:0]        lmag;
   logic                    start_ok, thr_met, busy_a, done_c, bal_fire;
   bal_in_type              bal_i;
   bal_out_type             bal_o;

   logic [DUTY_W-1:0]       ch0_c, ch1_c, ch2_c, ch3_c;

   always_comb begin
      move_a = move_ff;
      lcnt_a = lcnt_ff;
      rcnt_a = rcnt_ff;
      ticks_a = ticks_ff;

      start_ok = (cmd_ff == CMD_START) && (move_ff == MV_IDLE);
      case (cmd_ff)
         CMD_START: begin
            if (start_ok) begin
               case (kind_ff)
                  KIND_FORWARD: move_a = MV_FORWARD;
                  KIND_BACK:    move_a = MV_BACK;
                  KIND_RIGHT:   move_a = MV_RIGHT;
                  KIND_LEFT:    move_a = MV_LEFT;
                  default:      move_a = MV_IDLE;   // stop or unknown: no effect
               endcase
               if (move_a != MV_IDLE) begin
                  lcnt_a = '0;
                  rcnt_a = '0;
               end
            end
         end
         CMD_LEFT_EDGE: begin
            // left decoder counts up when A equals B
            if (pa_ff == pb_ff) lcnt_a = (lcnt_ff == CNT_MAX) ? lcnt_ff : lcnt_ff + CNT_W'(1);
            else                lcnt_a = (lcnt_ff == CNT_MIN) ? lcnt_ff : lcnt_ff - CNT_W'(1);
         end
         CMD_RIGHT_EDGE: begin
            // right decoder is mirrored
            if (pa_ff != pb_ff) rcnt_a = (rcnt_ff == CNT_MAX) ? rcnt_ff : rcnt_ff + CNT_W'(1);
            else                rcnt_a = (rcnt_ff == CNT_MIN) ? rcnt_ff : rcnt_ff - CNT_W'(1);
         end
         CMD_TICK: begin
            if (ticks_ff != TICKS_SAT) ticks_a = ticks_ff + 2'd1;
         end
         default: ;
      endcase

      lmag = lcnt_a[CNT_W-1] ? (CNT_W-1)'(-lcnt_a) : lcnt_a[CNT_W-2:0];
      case (move_a)
         MV_FORWARD: thr_met = lcnt_a >= $signed({1'b0, fwd_dist_ff});
         MV_BACK:    thr_met = lmag >= back_dist_ff;
         MV_RIGHT:   thr_met = lcnt_a >= $signed({1'b0, right_dist_ff});
         MV_LEFT:    thr_met = rcnt_a >= $signed({1'b0, left_dist_ff});
         default:    thr_met = 1'b1;
      endcase

      busy_a   = move_a != MV_IDLE;
      done_c   = busy_a && thr_met;
      bal_fire = busy_a && !thr_met && (cmd_ff == CMD_TICK) && (ticks_a >= TICKS_DUE);

      bal_i.move        = move_a;
      bal_i.left_count  = lcnt_a;
      bal_i.right_count = rcnt_a;
      bal_i.left_seen   = lseen_ff;
      bal_i.right_seen  = rseen_ff;
      bal_i.left_duty   = lduty_ff;
      bal_i.right_duty  = rduty_ff;
      bal_i.left_min    = lmin_ff;
      bal_i.left_max    = lmax_ff;
      bal_i.right_min   = rmin_ff;
      bal_i.right_max   = rmax_ff;
   end

   ebdc_balance u_balance (
      .bal_i (bal_i),
      .bal_o (bal_o)
   );

   always_comb begin
      move_in  = move_a;
      lcnt_in  = lcnt_a;
      rcnt_in  = rcnt_a;
      lseen_in = lseen_ff;
      rseen_in = rseen_ff;
      lduty_in = lduty_ff;
      rduty_in = rduty_ff;
      if (done_c) begin
         // threshold reached: the move ends and the counts restart
         move_in = MV_IDLE;
         lcnt_in = '0;
         rcnt_in = '0;
      end else if (bal_fire) begin
         lseen_in = bal_o.left_seen;
         rseen_in = bal_o.right_seen;
         lduty_in = bal_o.left_duty;
         rduty_in = bal_o.right_duty;
      end
      ticks_in = bal_fire ? 2'd0 : ticks_a;

      // steer the duties onto the bridge inputs
      ch0_c = '0;
      ch1_c = '0;
      ch2_c = '0;
      ch3_c = '0;
      case (move_in)
         MV_FORWARD: begin ch1_c = lduty_in; ch3_c = rduty_in; end
         MV_BACK:    begin ch0_c = lduty_in; ch2_c = rduty_in; end
         MV_RIGHT:   begin ch1_c = lduty_in; ch2_c = rduty_in; end
         MV_LEFT:    begin ch0_c = lduty_in; ch3_c = rduty_in; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_ff  <= MV_IDLE;
         lcnt_ff  <= '0;
         rcnt_ff  <= '0;
         lseen_ff <= '0;
         rseen_ff <= '0;
         lduty_ff <= LDUTY_RST;
         rduty_ff <= RDUTY_RST;
         ticks_ff <= TICKS_RST;
      end else if (adv) begin
         move_ff  <= move_in;
         lcnt_ff  <= lcnt_in;
         rcnt_ff  <= rcnt_in;
         lseen_ff <= lseen_in;
         rseen_ff <= rseen_in;
         lduty_ff <= lduty_in;
         rduty_ff <= rduty_in;
         ticks_ff <= ticks_in;
      end
   end

   // response register (payload)
   logic [47:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {6'd0, done_c, (move_in != MV_IDLE), ch3_c, ch2_c, ch1_c, ch0_c};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // ---------------- assertions ----------------
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_data_ff[41]) |-> (!rsp_data_ff[40] && rsp_data_ff[39:0] == '0))
      else $error("move_done reported with busy or non-zero duties");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && done_c) |=> (lcnt_ff == '0 && rcnt_ff == '0 && move_ff == MV_IDLE))
      else $error("counts or move not cleared at end of move");

   a_lduty_max: assert property (@(posedge clock) disable iff (reset)
      (adv && bal_fire) |=> (lduty_ff <= $past(lmax_ff) && rduty_ff <= $past(rmax_ff)))
      else $error("balance step left a duty above its upper limit");

   a_tick_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && bal_fire) |=> (ticks_ff == '0))
      else $error("tick timer not cleared by balance step");

endmodule

`default_nettype wire
